// ----- rtl/core/mrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the motif run code
// reverse complement pipeline. No dependencies.
package mrc_pkg;

  localparam int MAX_MOTIF_LEN = 6;
  localparam int CODE_W        = 15;
  localparam int LEN_W         = 3;
  localparam int OVER_W        = 3;
  localparam int MOTIF_W       = 2 * MAX_MOTIF_LEN;
  localparam int RECIP_SHIFT   = 18;
  localparam int RECIP_W       = 18;
  localparam int PROD_W        = CODE_W + RECIP_W;

  // Rounded-up reciprocals of the motif lengths. With an 18-bit shift the
  // quotient of any 15-bit dividend comes out exact without a correction.
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((1 << RECIP_SHIFT) + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((1 << RECIP_SHIFT) + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((1 << RECIP_SHIFT) + 4) / 5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);

  // Start of the code range that belongs to motifs of length len.
  function automatic logic [CODE_W-1:0] range_offset(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] sum;
    sum = '0;
    for (int i = 1; i <= MAX_MOTIF_LEN; i++) begin
      if (LEN_W'(i) < len) begin
        sum = sum + CODE_W'((1 << (2 * i)) * i);
      end
    end
    return sum;
  endfunction

  function automatic logic [RECIP_W-1:0] len_recip(input logic [LEN_W-1:0] len);
    logic [RECIP_W-1:0] r;
    case (len)
      3'd2:    r = RECIP_2;
      3'd3:    r = RECIP_3;
      3'd4:    r = RECIP_4;
      3'd5:    r = RECIP_5;
      3'd6:    r = RECIP_6;
      default: r = '0;
    endcase
    return r;
  endfunction

  localparam logic [CODE_W-1:0] TOTAL_CODES = range_offset(LEN_W'(MAX_MOTIF_LEN + 1));

  typedef struct packed {
    logic              ok;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] rest;
  } dec_t;

  typedef struct packed {
    logic               ok;
    logic [LEN_W-1:0]   len;
    logic [CODE_W-1:0]  rest;
    logic [MOTIF_W-1:0] motif;
  } div_t;

  typedef struct packed {
    logic               ok;
    logic [LEN_W-1:0]   len;
    logic [OVER_W-1:0]  over;
    logic [MOTIF_W-1:0] motif;
  } rot_t;

endpackage

// ----- rtl/core/motif_run_code_reverse_complement.sv -----
`timescale 1ns / 1ps
// Motif run code reverse complement: takes one run code per cycle while not
// stalled and returns the code of its reverse complemented motif through four
// register stages (length decode, reciprocal divide, rotate and complement,
// re-encode). Throughput is one transaction per cycle; a stall on the output
// freezes only the stages that hold data, so bubbles are squeezed out.
// Codes at or above 30948 return zero with code_valid_o low.
// Depends on mrc_pkg and the four mrc stage modules.
module motif_run_code_reverse_complement (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [mrc_pkg::CODE_W-1:0] run_code_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [mrc_pkg::CODE_W-1:0] complement_code_o,
  output logic                       code_valid_o
);
  import mrc_pkg::*;

  logic dec_valid, div_valid, rot_valid;
  logic dec_ready, div_ready, rot_ready, enc_ready;
  dec_t dec_data;
  div_t div_data;
  rot_t rot_data;

  mrc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .code_i  (run_code_i),
    .ready_i (div_ready),
    .ready_o (dec_ready),
    .valid_o (dec_valid),
    .data_o  (dec_data)
  );

  mrc_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .data_i  (dec_data),
    .ready_i (rot_ready),
    .ready_o (div_ready),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  mrc_revcomp u_revcomp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .data_i  (div_data),
    .ready_i (enc_ready),
    .ready_o (rot_ready),
    .valid_o (rot_valid),
    .data_o  (rot_data)
  );

  mrc_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .data_i  (rot_data),
    .ready_i (!stall_i),
    .ready_o (enc_ready),
    .valid_o (valid_o),
    .code_o  (complement_code_o),
    .ok_o    (code_valid_o)
  );

  assign stall_o = !dec_ready;

endmodule

// ----- rtl/core/mrc_decode.sv -----
`timescale 1ns / 1ps
// Stage 1: finds the motif length from the code ranges and strips the offset.
// Depends on mrc_pkg.
module mrc_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [mrc_pkg::CODE_W-1:0] code_i,
  input  logic                      ready_i,
  output logic                      ready_o,
  output logic                      valid_o,
  output mrc_pkg::dec_t             data_o
);
  import mrc_pkg::*;

  logic valid_q;
  dec_t data_d, data_q;

  always_comb begin
    logic [LEN_W-1:0] len;
    len = LEN_W'(1);
    for (int l = 2; l <= MAX_MOTIF_LEN; l++) begin
      if (code_i >= range_offset(LEN_W'(l))) begin
        len = LEN_W'(l);
      end
    end
    data_d.ok   = code_i < TOTAL_CODES;
    data_d.len  = len;
    data_d.rest = code_i - range_offset(len);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/mrc_divide.sv -----
`timescale 1ns / 1ps
// Stage 2: divides the remaining code by the motif length through a
// reciprocal multiply to get the motif. Depends on mrc_pkg.
module mrc_divide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mrc_pkg::dec_t data_i,
  input  logic          ready_i,
  output logic          ready_o,
  output logic          valid_o,
  output mrc_pkg::div_t data_o
);
  import mrc_pkg::*;

  logic              valid_q;
  div_t              data_d, data_q;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(data_i.rest) * PROD_W'(len_recip(data_i.len));

  always_comb begin
    data_d.ok   = data_i.ok;
    data_d.len  = data_i.len;
    data_d.rest = data_i.rest;
    if (data_i.len == LEN_W'(1)) begin
      data_d.motif = data_i.rest[MOTIF_W-1:0];
    end else begin
      data_d.motif = prod[RECIP_SHIFT +: MOTIF_W];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/mrc_revcomp.sv -----
`timescale 1ns / 1ps
// Stage 3: recovers the overhang, rotates the motif by it, then reverses and
// complements the bases. Depends on mrc_pkg.
module mrc_revcomp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mrc_pkg::div_t data_i,
  input  logic          ready_i,
  output logic          ready_o,
  output logic          valid_o,
  output mrc_pkg::rot_t data_o
);
  import mrc_pkg::*;

  logic valid_q;
  rot_t data_d, data_q;

  always_comb begin
    logic [CODE_W-1:0]  used;
    logic [OVER_W-1:0]  over;
    logic [LEN_W-1:0]   keep;
    logic [MOTIF_W-1:0] rot;
    logic [MOTIF_W-1:0] rev;
    used = CODE_W'(data_i.motif) * CODE_W'(data_i.len);
    over = OVER_W'(data_i.rest - used);
    keep = data_i.len - over;
    // Rotate left by the overhang; with no overhang the right shift empties.
    rot  = (data_i.motif << {over, 1'b0}) | (data_i.motif >> {keep, 1'b0});
    for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
      rev[2*i +: 2] = ~rot[2*(MAX_MOTIF_LEN-1-i) +: 2];
    end
    // Bases above the motif, which may hold bits pushed up by the rotate, fall off here.
    data_d.motif = rev >> {LEN_W'(MAX_MOTIF_LEN) - data_i.len, 1'b0};
    data_d.ok    = data_i.ok;
    data_d.len   = data_i.len;
    data_d.over  = over;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/mrc_encode.sv -----
`timescale 1ns / 1ps
// Stage 4: packs the complemented motif back into a run code and holds the
// output register. Depends on mrc_pkg.
module mrc_encode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  mrc_pkg::rot_t              data_i,
  input  logic                       ready_i,
  output logic                       ready_o,
  output logic                       valid_o,
  output logic [mrc_pkg::CODE_W-1:0] code_o,
  output logic                       ok_o
);
  import mrc_pkg::*;

  logic              valid_q;
  logic [CODE_W-1:0] code_d, code_q;
  logic              ok_q;

  always_comb begin
    logic [CODE_W-1:0] scaled;
    scaled = CODE_W'(data_i.motif) * CODE_W'(data_i.len);
    code_d = range_offset(data_i.len) + scaled + CODE_W'(data_i.over);
    if (!data_i.ok) begin
      code_d = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      code_q <= code_d;
      ok_q   <= data_i.ok;
    end
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;
  assign ok_o    = ok_q;

endmodule
